### hdl/jms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jms_pkg: shared types and constants
// Pipeline depth and the field bundles that pass between the datapath parts.
// ----------------------------------------------------------------------------
package jms_pkg;

  // Total register stages, input capture through output register.
  localparam int STAGES       = 21;
  // Stages that split the timestamp into day number and time of day.
  localparam int FRONT_STAGES = 4;
  // Stages of the date and time-of-day paths, between front and output.
  localparam int MID_STAGES   = STAGES - FRONT_STAGES - 1;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] msec;
  } tod_t;

  typedef struct packed {
    logic [14:0] cyear;   // Meeus C, year plus 4715 or 4716
    logic [3:0]  month;
    logic [4:0]  day;
  } ymd_t;

endpackage
`default_nettype wire

### hdl/jms_pipe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jms_pipe_ctrl: stage valid bits and load enables
// A stage loads when any stage at or after it is empty, or the output is taken.
// ----------------------------------------------------------------------------
module jms_pipe_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jms_pkg::STAGES-1:0]  stage_en
);
  import jms_pkg::*;

  logic [STAGES-1:0] valid_r, valid_nxt;

  // each enable is an independent reduction over the downstream valid bits
  for (genvar g = 0; g < STAGES; g++) begin : g_en
    assign stage_en[g] = out_ready || !(&valid_r[STAGES-1:g]);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (stage_en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid_r[STAGES-1];

  // requests in flight change only by what enters and what leaves
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(valid_r) == $past($countones(valid_r))
        + $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready))))
    else $error("pipeline request count not conserved");

  // a full pipeline under back-pressure keeps every request
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((&valid_r) && !out_ready) |=> (&valid_r))
    else $error("request dropped while stalled");

endmodule
`default_nettype wire

### hdl/jms_day_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jms_day_split: timestamp to civil day number and millisecond of day
// Clamp, add half a day, divide by 86400000 by reciprocal and fix-up.
// ----------------------------------------------------------------------------
module jms_day_split (
  input  logic        clk,
  input  logic [3:0]  stage_en,
  input  logic [48:0] in_julian_ms,
  output logic [22:0] day_num,
  output logic [26:0] day_ms
);

  localparam logic [48:0] MIN_MS      = 49'd161327505600000;
  localparam logic [49:0] HALF_DAY_MS = 50'd43200000;
  localparam logic [28:0] DAY_MS      = 29'd86400000;
  localparam logic [28:0] TWO_DAY_MS  = 29'd172800000;
  // floor(2^50 / 86400000), applied to the top 32 bits of the dividend
  localparam logic [23:0] DAY_RECIP   = 24'((64'd1 << 50) / 64'd86400000);

  logic [48:0] t_sat;
  logic [49:0] shifted_r, shifted_nxt;
  logic [55:0] zprod;
  logic [22:0] zq1_r, zq1_nxt;
  logic [28:0] lo1_r;
  logic [22:0] zq2_r;
  logic [28:0] zr2_r, zr2_nxt;
  logic [22:0] z3_r, z3_nxt;
  logic [26:0] r3_r, r3_nxt;

  always_comb begin
    t_sat       = (in_julian_ms < MIN_MS) ? MIN_MS : in_julian_ms;
    shifted_nxt = {1'b0, t_sat} + HALF_DAY_MS;
    // estimate lands at most two below the true quotient
    zprod       = shifted_r[49:18] * DAY_RECIP;
    zq1_nxt     = zprod[54:32];
    // remainder below three days: low 29 bits are exact
    zr2_nxt     = lo1_r - (29'(zq1_r) * DAY_MS);
    priority if (zr2_r >= TWO_DAY_MS) begin
      z3_nxt = zq2_r + 23'd2;
      r3_nxt = 27'(zr2_r - TWO_DAY_MS);
    end else if (zr2_r >= DAY_MS) begin
      z3_nxt = zq2_r + 23'd1;
      r3_nxt = 27'(zr2_r - DAY_MS);
    end else begin
      z3_nxt = zq2_r;
      r3_nxt = zr2_r[26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      shifted_r <= shifted_nxt;
    end
    if (stage_en[1]) begin
      zq1_r <= zq1_nxt;
      lo1_r <= shifted_r[28:0];
    end
    if (stage_en[2]) begin
      zq2_r <= zq1_r;
      zr2_r <= zr2_nxt;
    end
    if (stage_en[3]) begin
      z3_r <= z3_nxt;
      r3_r <= r3_nxt;
    end
  end

  assign day_num = z3_r;
  assign day_ms  = r3_r;

endmodule
`default_nettype wire

### hdl/jms_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jms_date: day number to Meeus C, month and day
// Three constant divisions (A, C, E), each as estimate, remainder, fix-up.
// ----------------------------------------------------------------------------
module jms_date (
  input  logic                           clk,
  input  logic [jms_pkg::MID_STAGES-1:0] stage_en,
  input  logic [22:0]                    day_num,
  output jms_pkg::ymd_t                  ymd
);
  import jms_pkg::*;

  localparam logic [24:0] XA_OFS   = 25'd7468865;
  localparam logic [7:0]  A_RECIP  = 8'((64'd1 << 25) / 64'd146097);
  localparam logic [18:0] A_DIV    = 19'd146097;
  localparam logic [22:0] B_OFS    = 23'd1525;
  localparam logic [26:0] XC_OFS   = 27'd2442;
  localparam logic [14:0] C_RECIP  = 15'((64'd1 << 27) / 64'd7305);
  localparam logic [13:0] C_DIV    = 14'd7305;
  localparam logic [22:0] YR_DAYS  = 23'd365;
  localparam logic [23:0] XE_SCALE = 24'd10000;
  localparam logic [5:0]  E_RECIP  = 6'((64'd1 << 24) / 64'd306001);
  localparam logic [19:0] E_DIV    = 20'd306001;

  // floor(30.6001 * e): days from the start of month e of the March-based year
  function automatic logic [8:0] month_start(input logic [4:0] e);
    logic [8:0] v;
    unique case (e)
      5'd4:    v = 9'd122;
      5'd5:    v = 9'd153;
      5'd6:    v = 9'd183;
      5'd7:    v = 9'd214;
      5'd8:    v = 9'd244;
      5'd9:    v = 9'd275;
      5'd10:   v = 9'd306;
      5'd11:   v = 9'd336;
      5'd12:   v = 9'd367;
      5'd13:   v = 9'd397;
      5'd14:   v = 9'd428;
      5'd15:   v = 9'd459;
      5'd16:   v = 9'd489;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  logic [24:0] xa0_r, xa0_nxt, xa1_r;
  logic [22:0] z0_r, z1_r, z2_r, z3_r;
  logic [32:0] aprod;
  logic [6:0]  aq1_r, aq1_nxt, aq2_r;
  logic [18:0] ar2_r, ar2_nxt;
  logic [6:0]  a3_r, a3_nxt;
  logic [22:0] b4_r, b4_nxt, b5_r, b6_r, b7_r, b8_r, b9_r;
  logic [26:0] xc5_r, xc5_nxt, xc6_r;
  logic [41:0] cprod;
  logic [14:0] cq6_r, cq6_nxt, cq7_r;
  logic [13:0] cr7_r, cr7_nxt;
  logic [14:0] c8_r, c8_nxt, c9_r, c10_r, c11_r, c12_r, c13_r, c14_r;
  logic [22:0] d9_r, d9_nxt;
  logic [9:0]  bd10_r, bd10_nxt, bd11_r, bd12_r, bd13_r, bd14_r;
  logic [23:0] xe11_r, xe11_nxt, xe12_r;
  logic [29:0] eprod;
  logic [4:0]  eq12_r, eq12_nxt, eq13_r;
  logic [19:0] er13_r, er13_nxt;
  logic [4:0]  e14_r, e14_nxt;
  ymd_t        ymd_r, ymd_nxt;

  always_comb begin
    xa0_nxt  = {day_num, 2'b00} - XA_OFS;
    aprod    = xa0_r * A_RECIP;
    aq1_nxt  = aprod[31:25];
    ar2_nxt  = xa1_r[18:0] - (19'(aq1_r) * A_DIV);
    a3_nxt   = (ar2_r >= A_DIV) ? aq2_r + 7'd1 : aq2_r;
    b4_nxt   = z3_r + 23'(a3_r) - 23'(a3_r[6:2]) + B_OFS;
    xc5_nxt  = {b4_r, 4'b0000} + {2'b00, b4_r, 2'b00} - XC_OFS;
    cprod    = xc5_r * C_RECIP;
    cq6_nxt  = cprod[41:27];
    cr7_nxt  = xc6_r[13:0] - (14'(cq6_r) * C_DIV);
    c8_nxt   = (cr7_r >= C_DIV) ? cq7_r + 15'd1 : cq7_r;
    // 36525*C/100 is exactly 365*C + C/4
    d9_nxt   = (23'(c8_r) * YR_DAYS) + 23'(c8_r[14:2]);
    bd10_nxt = b9_r[9:0] - d9_r[9:0];
    xe11_nxt = 24'(bd10_r) * XE_SCALE;
    eprod    = xe11_r * E_RECIP;
    eq12_nxt = eprod[28:24];
    er13_nxt = xe12_r[19:0] - (20'(eq12_r) * E_DIV);
    e14_nxt  = (er13_r >= E_DIV) ? eq13_r + 5'd1 : eq13_r;

    ymd_nxt.cyear = c14_r;
    ymd_nxt.day   = 5'(bd14_r - 10'(month_start(e14_r)));
    ymd_nxt.month = (e14_r < 5'd14) ? 4'(e14_r - 5'd1) : 4'(e14_r - 5'd13);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      xa0_r <= xa0_nxt;
      z0_r  <= day_num;
    end
    if (stage_en[1]) begin
      aq1_r <= aq1_nxt;
      xa1_r <= xa0_r;
      z1_r  <= z0_r;
    end
    if (stage_en[2]) begin
      ar2_r <= ar2_nxt;
      aq2_r <= aq1_r;
      z2_r  <= z1_r;
    end
    if (stage_en[3]) begin
      a3_r <= a3_nxt;
      z3_r <= z2_r;
    end
    if (stage_en[4]) begin
      b4_r <= b4_nxt;
    end
    if (stage_en[5]) begin
      xc5_r <= xc5_nxt;
      b5_r  <= b4_r;
    end
    if (stage_en[6]) begin
      cq6_r <= cq6_nxt;
      xc6_r <= xc5_r;
      b6_r  <= b5_r;
    end
    if (stage_en[7]) begin
      cr7_r <= cr7_nxt;
      cq7_r <= cq6_r;
      b7_r  <= b6_r;
    end
    if (stage_en[8]) begin
      c8_r <= c8_nxt;
      b8_r <= b7_r;
    end
    if (stage_en[9]) begin
      d9_r <= d9_nxt;
      b9_r <= b8_r;
      c9_r <= c8_r;
    end
    if (stage_en[10]) begin
      bd10_r <= bd10_nxt;
      c10_r  <= c9_r;
    end
    if (stage_en[11]) begin
      xe11_r <= xe11_nxt;
      bd11_r <= bd10_r;
      c11_r  <= c10_r;
    end
    if (stage_en[12]) begin
      eq12_r <= eq12_nxt;
      xe12_r <= xe11_r;
      bd12_r <= bd11_r;
      c12_r  <= c11_r;
    end
    if (stage_en[13]) begin
      er13_r <= er13_nxt;
      eq13_r <= eq12_r;
      bd13_r <= bd12_r;
      c13_r  <= c12_r;
    end
    if (stage_en[14]) begin
      e14_r  <= e14_nxt;
      bd14_r <= bd13_r;
      c14_r  <= c13_r;
    end
    if (stage_en[15]) begin
      ymd_r <= ymd_nxt;
    end
  end

  assign ymd = ymd_r;

endmodule
`default_nettype wire

### hdl/jms_tod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jms_tod: millisecond of day to hour, minute, second, millisecond
// Divides by 1000, 3600 and 60, then delays to line up with the date path.
// ----------------------------------------------------------------------------
module jms_tod (
  input  logic                           clk,
  input  logic [jms_pkg::MID_STAGES-1:0] stage_en,
  input  logic [26:0]                    day_ms,
  output jms_pkg::tod_t                  tod
);
  import jms_pkg::*;

  localparam logic [17:0] S_RECIP = 18'((64'd1 << 27) / 64'd1000);
  localparam logic [10:0] MS_DIV  = 11'd1000;
  localparam logic [5:0]  H_RECIP = 6'((64'd1 << 17) / 64'd3600);
  localparam logic [12:0] H_DIV   = 13'd3600;
  localparam logic [6:0]  M_RECIP = 7'((64'd1 << 12) / 64'd60);
  localparam logic [6:0]  M_DIV   = 7'd60;
  localparam int          DLY     = MID_STAGES - 9;

  logic [44:0] sprod;
  logic [26:0] r0_r;
  logic [16:0] sq0_r, sq0_nxt, sq1_r;
  logic [10:0] sr1_r, sr1_nxt;
  logic [16:0] secs2_r, secs2_nxt, secs3_r;
  logic [9:0]  msec2_r, msec2_nxt, msec3_r, msec4_r, msec5_r, msec6_r, msec7_r;
  logic [22:0] hprod;
  logic [4:0]  hq3_r, hq3_nxt, hq4_r;
  logic [12:0] hr4_r, hr4_nxt;
  logic [4:0]  hour5_r, hour5_nxt, hour6_r, hour7_r;
  logic [11:0] rem5_r, rem5_nxt, rem6_r;
  logic [18:0] mprod;
  logic [5:0]  mq6_r, mq6_nxt, mq7_r;
  logic [6:0]  mr7_r, mr7_nxt;
  tod_t        tod8_r, tod8_nxt;
  tod_t        dly_r [DLY];

  always_comb begin
    sprod   = day_ms * S_RECIP;
    sq0_nxt = sprod[43:27];
    sr1_nxt = r0_r[10:0] - (11'(sq0_r) * MS_DIV);
    if (sr1_r >= MS_DIV) begin
      secs2_nxt = sq1_r + 17'd1;
      msec2_nxt = 10'(sr1_r - MS_DIV);
    end else begin
      secs2_nxt = sq1_r;
      msec2_nxt = sr1_r[9:0];
    end
    hprod   = secs2_r * H_RECIP;
    hq3_nxt = hprod[21:17];
    hr4_nxt = secs3_r[12:0] - (13'(hq3_r) * H_DIV);
    if (hr4_r >= H_DIV) begin
      hour5_nxt = hq4_r + 5'd1;
      rem5_nxt  = 12'(hr4_r - H_DIV);
    end else begin
      hour5_nxt = hq4_r;
      rem5_nxt  = hr4_r[11:0];
    end
    mprod   = rem5_r * M_RECIP;
    mq6_nxt = mprod[17:12];
    mr7_nxt = rem6_r[6:0] - (7'(mq6_r) * M_DIV);
    tod8_nxt.hour = hour7_r;
    tod8_nxt.msec = msec7_r;
    if (mr7_r >= M_DIV) begin
      tod8_nxt.minute = mq7_r + 6'd1;
      tod8_nxt.second = 6'(mr7_r - M_DIV);
    end else begin
      tod8_nxt.minute = mq7_r;
      tod8_nxt.second = mr7_r[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      sq0_r <= sq0_nxt;
      r0_r  <= day_ms;
    end
    if (stage_en[1]) begin
      sr1_r <= sr1_nxt;
      sq1_r <= sq0_r;
    end
    if (stage_en[2]) begin
      secs2_r <= secs2_nxt;
      msec2_r <= msec2_nxt;
    end
    if (stage_en[3]) begin
      hq3_r   <= hq3_nxt;
      secs3_r <= secs2_r;
      msec3_r <= msec2_r;
    end
    if (stage_en[4]) begin
      hr4_r   <= hr4_nxt;
      hq4_r   <= hq3_r;
      msec4_r <= msec3_r;
    end
    if (stage_en[5]) begin
      hour5_r <= hour5_nxt;
      rem5_r  <= rem5_nxt;
      msec5_r <= msec4_r;
    end
    if (stage_en[6]) begin
      mq6_r   <= mq6_nxt;
      rem6_r  <= rem5_r;
      hour6_r <= hour5_r;
      msec6_r <= msec5_r;
    end
    if (stage_en[7]) begin
      mr7_r   <= mr7_nxt;
      mq7_r   <= mq6_r;
      hour7_r <= hour6_r;
      msec7_r <= msec6_r;
    end
    if (stage_en[8]) begin
      tod8_r <= tod8_nxt;
    end
  end

  // alignment delay up to the date path's last stage
  for (genvar g = 0; g < DLY; g++) begin : g_dly
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (stage_en[9]) begin
          dly_r[0] <= tod8_r;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (stage_en[9+g]) begin
          dly_r[g] <= dly_r[g-1];
        end
      end
    end
  end

  assign tod = dly_r[DLY-1];

endmodule
`default_nettype wire

### hdl/julian_ms_to_calendar_fields_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// julian_ms_to_calendar_fields_unit: Julian-day milliseconds to calendar fields
// Pipelined Meeus conversion to proleptic Gregorian date and time of day.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   in_      | in_valid / in_ready  | julian_ms (49b)
//   out_     | out_valid / out_ready| year, month, day, hour, minute,
//            |                      | second, millisecond
//
// Throughput: one request per clock unless back-pressure fills the pipeline.
// The 21-stage pipeline holds the day split, three reciprocal divisions on
// the date path, and the output register.
// Reset clears only the stage valid bits; datapath registers are not reset.
// Stalls: a stage holds while it and every stage after it are full and
// out_ready is low; empty stages keep filling, so bubbles are squeezed out.
//
// Stage map:
//   0..3   clamp, +half day, divide by 86400000 -> day number, ms of day
//   4..19  date path (A, B, C, D, E, month, day) in parallel with the
//          time-of-day path (/1000, /3600, /60) plus its alignment delay
//   20     year select and output register
// Each constant division runs as reciprocal multiply, remainder, fix-up.
// ----------------------------------------------------------------------------
module julian_ms_to_calendar_fields_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [48:0] in_julian_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [9:0]  out_millisecond
);
  import jms_pkg::*;

  // C minus 4716 from March on, minus 4715 for January and February
  localparam logic [14:0] YR_OFS_LATE  = 15'd4716;
  localparam logic [14:0] YR_OFS_EARLY = 15'd4715;
  localparam logic [3:0]  FEB          = 4'd2;

  logic [STAGES-1:0] stage_en;
  logic [22:0]       day_num;
  logic [26:0]       day_ms;
  ymd_t              ymd;
  tod_t              tod;

  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  tod_t        tod_r;

  jms_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  jms_day_split u_split (
    .clk          (clk),
    .stage_en     (stage_en[FRONT_STAGES-1:0]),
    .in_julian_ms (in_julian_ms),
    .day_num      (day_num),
    .day_ms       (day_ms)
  );

  jms_date u_date (
    .clk      (clk),
    .stage_en (stage_en[STAGES-2:FRONT_STAGES]),
    .day_num  (day_num),
    .ymd      (ymd)
  );

  jms_tod u_tod (
    .clk      (clk),
    .stage_en (stage_en[STAGES-2:FRONT_STAGES]),
    .day_ms   (day_ms),
    .tod      (tod)
  );

  always_comb begin
    if (ymd.month > FEB) begin
      year_nxt = 14'(ymd.cyear - YR_OFS_LATE);
    end else begin
      year_nxt = 14'(ymd.cyear - YR_OFS_EARLY);
    end
  end

  // output register: payload only, valid lives in the control block
  always_ff @(posedge clk) begin
    if (stage_en[STAGES-1]) begin
      year_r  <= year_nxt;
      month_r <= ymd.month;
      day_r   <= ymd.day;
      tod_r   <= tod;
    end
  end

  assign out_year        = year_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_hour        = tod_r.hour;
  assign out_minute      = tod_r.minute;
  assign out_second      = tod_r.second;
  assign out_millisecond = tod_r.msec;

  // every valid result has each field within its calendar range
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day != 5'd0) &&
                  (out_hour <= 5'd23) && (out_minute <= 6'd59) &&
                  (out_second <= 6'd59) && (out_millisecond <= 10'd999))
    else $error("result field out of calendar range");

endmodule
`default_nettype wire
